>>> hw/rtl/mpq_pkg.sv
package mpq_pkg;

    localparam int LEVELS      = 16;
    localparam int LEVEL_DEPTH = 64;
    localparam int TAG_BITS    = 16;

    localparam int STORE_SIZE = LEVELS * LEVEL_DEPTH;
    localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int IDX_W      = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W     = $clog2(STORE_SIZE);

    localparam int REQ_W      = 2;
    localparam int PRIO_W     = 4;
    localparam int ITEM_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int LEVEL_W    = 4;
    localparam int QNT_W      = 13;
    localparam int BASE_W     = 10;
    localparam int STEP_W     = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(50);
    localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(20);

    typedef logic [LVL_W-1:0]  lvl_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [QNT_W-1:0]  qnt_t;
    typedef logic [BASE_W-1:0] base_t;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ     = 2'd0,
        REQ_DEQ     = 2'd1,
        REQ_PEEK    = 2'd2,
        REQ_QUANTUM = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_QUANTUM_BASE = 1'd0,
        CFG_QUANTUM_STEP = 1'd1
    } cfg_reg_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    function automatic lvl_t clamp_level(input logic [PRIO_W-1:0] pr);
        logic [PRIO_W:0] wide;
        wide = {1'b0, pr};
        if (wide >= (PRIO_W+1)'(LEVELS - 1))
            return lvl_t'(LEVELS - 1);
        return lvl_t'(pr);
    endfunction

    function automatic addr_t store_addr(input lvl_t lv, input idx_t ix);
        return addr_t'(lv) * addr_t'(LEVEL_DEPTH) + addr_t'(ix);
    endfunction

    function automatic idx_t next_idx(input idx_t i);
        return (i == idx_t'(LEVEL_DEPTH - 1)) ? '0 : i + idx_t'(1);
    endfunction

    function automatic qnt_t quantum_of(input base_t b, input step_t s, input lvl_t lv);
        return qnt_t'(b) + qnt_t'(s) * qnt_t'(lv);
    endfunction

endpackage

>>> hw/rtl/mpq_req_if.sv
interface mpq_req_if;
    logic                           valid;
    logic                           ready;
    logic [mpq_pkg::REQ_W-1:0]      req_type;
    logic [mpq_pkg::PRIO_W-1:0]     priority_req;
    logic [mpq_pkg::ITEM_W-1:0]     item_id;

    modport source (output valid, output req_type, output priority_req, output item_id,
                    input ready);
    modport sink   (input valid, input req_type, input priority_req, input item_id,
                    output ready);
endinterface

>>> hw/rtl/mpq_rsp_if.sv
interface mpq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [mpq_pkg::ITEM_W-1:0]     out_item;
    logic [mpq_pkg::STATUS_W-1:0]   status;
    logic [mpq_pkg::LEVEL_W-1:0]    served_level;
    logic [mpq_pkg::QNT_W-1:0]      quantum_size;
    logic                           all_empty;

    modport source (output valid, output out_item, output status, output served_level,
                    output quantum_size, output all_empty, input ready);
    modport sink   (input valid, input out_item, input status, input served_level,
                    input quantum_size, input all_empty, output ready);
endinterface

>>> hw/rtl/mpq_cfg_if.sv
interface mpq_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mpq_pkg::CFG_ADDR_W-1:0]   addr;
    logic [mpq_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

>>> hw/rtl/mpq_ram.sv
module mpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/mpq_ctrl.sv
module mpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  mpq_pkg::dp_status_t stat,
    output mpq_pkg::dp_cmd_t    cmd
);

    mpq_pkg::ctrl_state_t state_reg;
    mpq_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mpq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = mpq_pkg::S_EXEC;
                end
            end
            mpq_pkg::S_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = mpq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mpq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            mpq_pkg::S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            mpq_pkg::S_EXEC:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/mpq_dp.sv
module mpq_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mpq_pkg::dp_cmd_t              cmd,
    output mpq_pkg::dp_status_t           stat,
    input  logic [mpq_pkg::REQ_W-1:0]     req_type,
    input  logic [mpq_pkg::PRIO_W-1:0]    priority_req,
    input  logic [mpq_pkg::ITEM_W-1:0]    item_id,
    mpq_cfg_if.sink                       cfg,
    mpq_rsp_if.source                     rsp
);

    // config registers
    mpq_pkg::base_t base_reg;
    mpq_pkg::step_t step_reg;

    // queue bookkeeping
    mpq_pkg::cnt_t count_reg [mpq_pkg::LEVELS];
    mpq_pkg::cnt_t count_next [mpq_pkg::LEVELS];
    mpq_pkg::idx_t head_reg [mpq_pkg::LEVELS];
    mpq_pkg::idx_t tail_reg [mpq_pkg::LEVELS];

    // captured request
    mpq_pkg::req_type_t req_type_reg;
    mpq_pkg::lvl_t      level_reg;
    mpq_pkg::tag_t      tag_reg;

    // result register
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [mpq_pkg::ITEM_W-1:0]        out_item_reg;
    mpq_pkg::status_t                  out_status_reg;
    logic [mpq_pkg::LEVEL_W-1:0]       out_level_reg;
    mpq_pkg::qnt_t                     out_qnt_reg;
    logic                              out_all_empty_reg;

    logic [mpq_pkg::LEVELS-1:0] ne;
    mpq_pkg::lvl_t              first_lvl;
    logic                       found;
    logic                       full;
    logic                       do_enq;
    logic                       do_deq;
    logic                       all_empty;
    mpq_pkg::status_t           res_status;
    mpq_pkg::lvl_t              res_lvl;
    logic [mpq_pkg::ITEM_W-1:0] res_item;
    mpq_pkg::qnt_t              res_qnt;
    logic                       res_has_lvl;
    logic                       wr_en;
    mpq_pkg::addr_t             wr_addr;
    mpq_pkg::addr_t             rd_addr;
    mpq_pkg::tag_t              rd_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= mpq_pkg::BASE_RST;
            step_reg <= mpq_pkg::STEP_RST;
        end
        else if (cfg.valid)
        begin
            unique case (mpq_pkg::cfg_reg_t'(cfg.addr))
                mpq_pkg::CFG_QUANTUM_BASE: base_reg <= cfg.data[mpq_pkg::BASE_W-1:0];
                mpq_pkg::CFG_QUANTUM_STEP: step_reg <= cfg.data[mpq_pkg::STEP_W-1:0];
                default: base_reg <= base_reg;
            endcase
        end
    end

    // strict priority search, level 0 wins
    always_comb
    begin
        first_lvl = '0;
        for (int i = mpq_pkg::LEVELS - 1; i >= 0; i--)
        begin
            ne[i] = (count_reg[i] != '0);
            if (ne[i])
            begin
                first_lvl = mpq_pkg::lvl_t'(i);
            end
        end
        found = |ne;
    end

    assign rd_addr = mpq_pkg::store_addr(first_lvl, head_reg[first_lvl]);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= mpq_pkg::req_type_t'(req_type);
            level_reg    <= mpq_pkg::clamp_level(priority_req);
            tag_reg      <= item_id[mpq_pkg::TAG_BITS-1:0];
        end
    end

    assign full = (count_reg[level_reg] == mpq_pkg::cnt_t'(mpq_pkg::LEVEL_DEPTH));

    always_comb
    begin
        do_enq      = 1'b0;
        do_deq      = 1'b0;
        res_status  = mpq_pkg::ST_OK;
        res_lvl     = level_reg;
        res_item    = '0;
        res_has_lvl = 1'b1;
        case (req_type_reg) inside
            mpq_pkg::REQ_ENQ:
            begin
                do_enq     = cmd.commit && !full;
                res_status = full ? mpq_pkg::ST_FULL : mpq_pkg::ST_OK;
            end
            mpq_pkg::REQ_DEQ, mpq_pkg::REQ_PEEK:
            begin
                if (found)
                begin
                    res_lvl  = first_lvl;
                    res_item = mpq_pkg::ITEM_W'(rd_data);
                    do_deq   = cmd.commit && (req_type_reg == mpq_pkg::REQ_DEQ);
                end
                else
                begin
                    res_status  = mpq_pkg::ST_EMPTY;
                    res_lvl     = '0;
                    res_has_lvl = 1'b0;
                end
            end
            default:
            begin
                res_lvl = level_reg;
            end
        endcase
        res_qnt = res_has_lvl ? mpq_pkg::quantum_of(base_reg, step_reg, res_lvl) : '0;
    end

    always_comb
    begin
        all_empty = 1'b1;
        for (int i = 0; i < mpq_pkg::LEVELS; i++)
        begin
            count_next[i] = count_reg[i];
            if (do_enq && (level_reg == mpq_pkg::lvl_t'(i)))
            begin
                count_next[i] = count_reg[i] + mpq_pkg::cnt_t'(1);
            end
            if (do_deq && (first_lvl == mpq_pkg::lvl_t'(i)))
            begin
                count_next[i] = count_reg[i] - mpq_pkg::cnt_t'(1);
            end
            if (count_next[i] != '0)
            begin
                all_empty = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mpq_pkg::LEVELS; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < mpq_pkg::LEVELS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
            if (do_enq)
            begin
                tail_reg[level_reg] <= mpq_pkg::next_idx(tail_reg[level_reg]);
            end
            if (do_deq)
            begin
                head_reg[first_lvl] <= mpq_pkg::next_idx(head_reg[first_lvl]);
            end
        end
    end

    assign wr_en   = do_enq;
    assign wr_addr = mpq_pkg::store_addr(level_reg, tail_reg[level_reg]);

    mpq_ram #(
        .WIDTH (mpq_pkg::TAG_BITS),
        .DEPTH (mpq_pkg::STORE_SIZE)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (tag_reg),
        .rd_en   (cmd.capture),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign stat.out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_item_reg      <= res_item;
            out_status_reg    <= res_status;
            out_level_reg     <= mpq_pkg::LEVEL_W'(res_lvl);
            out_qnt_reg       <= res_qnt;
            out_all_empty_reg <= all_empty;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_item     = out_item_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.served_level = out_level_reg;
    assign rsp.quantum_size = out_qnt_reg;
    assign rsp.all_empty    = out_all_empty_reg;

`ifndef SYNTHESIS
    a_commit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result register not loaded after commit");

    a_all_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (out_all_empty_reg == (ne == '0)))
        else $error("all_empty disagrees with level counts");

    a_capture_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !cmd.capture)
        else $error("second request captured while one is in flight");

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !cmd.commit)
        else $error("commit overwrote an untaken result");
`endif

endmodule

>>> hw/rtl/multilevel_priority_fifo_unit.sv
// A request transfer captures the request and reads the store; the update and result register load
// follow in the execute state, held back while the result channel stalls.
// A new request is taken only after the one before it has been committed to the result register.
// Reset (rst_n, async low): all levels empty, quantum base 50, step 20, no result pending.
// Store contents are not cleared; a store entry's data is only used after it was written.
module multilevel_priority_fifo_unit (
    input  logic      clk,
    input  logic      rst_n,
    mpq_req_if.sink   req,
    mpq_rsp_if.source rsp,
    mpq_cfg_if.sink   cfg
);

    mpq_pkg::dp_cmd_t    cmd;
    mpq_pkg::dp_status_t stat;
    logic                req_ready;

    assign req.ready = req_ready;

    mpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mpq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req.req_type),
        .priority_req (req.priority_req),
        .item_id      (req.item_id),
        .cfg          (cfg),
        .rsp          (rsp)
    );

endmodule

>>> test/multilevel_priority_fifo_unit_test.sv
module multilevel_priority_fifo_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpq_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 190;

    typedef struct {
        logic [ITEM_W-1:0]  item;
        status_t            status;
        logic [LEVEL_W-1:0] level;
        qnt_t               quant;
        logic               all_empty;
    } sched_result_t;

    class sched_queue_model;
        tag_t          level_fifo[LEVELS][$];
        base_t         base = BASE_RST;
        step_t         step = STEP_RST;
        sched_result_t pending_results[$];
        int            errors = 0;
        int            n_checked = 0;
        int            n_enq = 0;
        int            n_full = 0;
        int            n_deq = 0;
        int            n_peek = 0;
        int            n_empty = 0;
        int            n_quantum = 0;

        function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
            if (r == CFG_QUANTUM_BASE)
                base = d[BASE_W-1:0];
            else
                step = d[STEP_W-1:0];
        endfunction

        function qnt_t quantum(int lv);
            return qnt_t'(int'(base) + int'(step) * lv);
        endfunction

        function int queued();
            int total;
            total = 0;
            foreach (level_fifo[i])
                total += level_fifo[i].size();
            return total;
        endfunction

        function void note_request(req_type_t t, logic [PRIO_W-1:0] pr, logic [ITEM_W-1:0] id);
            sched_result_t r;
            int lv;
            int hit;
            lv = (int'(pr) >= LEVELS) ? LEVELS - 1 : int'(pr);
            r.item = '0;
            r.status = ST_OK;
            r.level = '0;
            r.quant = '0;
            case (t)
                REQ_ENQ:
                begin
                    n_enq++;
                    r.level = LEVEL_W'(lv);
                    r.quant = quantum(lv);
                    if (level_fifo[lv].size() >= LEVEL_DEPTH)
                    begin
                        r.status = ST_FULL;
                        n_full++;
                    end
                    else
                        level_fifo[lv].push_back(id[TAG_BITS-1:0]);
                end
                REQ_DEQ, REQ_PEEK:
                begin
                    if (t == REQ_DEQ)
                        n_deq++;
                    else
                        n_peek++;
                    hit = -1;
                    for (int i = LEVELS - 1; i >= 0; i--)
                        if (level_fifo[i].size() != 0)
                            hit = i;
                    if (hit < 0)
                    begin
                        r.status = ST_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        r.item = ITEM_W'(level_fifo[hit][0]);
                        r.level = LEVEL_W'(hit);
                        r.quant = quantum(hit);
                        if (t == REQ_DEQ)
                            void'(level_fifo[hit].pop_front());
                    end
                end
                default:
                begin
                    n_quantum++;
                    r.level = LEVEL_W'(lv);
                    r.quant = quantum(lv);
                end
            endcase
            r.all_empty = (queued() == 0);
            pending_results.push_back(r);
        endfunction

        function void report_mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
            errors++;
            $error("%s: expected %0d, actual %0d", field, want_v, got_v);
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $error("result transfer with no request pending, out_item %0d", got.item);
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (got.item !== want.item)
                report_mismatch("out_item", want.item, got.item);
            if (got.status !== want.status)
                report_mismatch("status", want.status, got.status);
            if (got.level !== want.level)
                report_mismatch("served_level", want.level, got.level);
            if (got.quant !== want.quant)
                report_mismatch("quantum_size", want.quant, got.quant);
            if (got.all_empty !== want.all_empty)
                report_mismatch("all_empty", want.all_empty, got.all_empty);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   hold_rsp;
    bit   burst;
    bit   idle_on;
    int   idle_count = 0;
    int   sent = 0;

    sched_queue_model model;
    sched_result_t    got_result;

    mpq_req_if req_ch();
    mpq_rsp_if rsp_ch();
    mpq_cfg_if cfg_ch();

    multilevel_priority_fifo_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                model.write_reg(cfg_reg_t'(cfg_ch.addr), cfg_ch.data);
            if (req_ch.valid && req_ch.ready)
                model.note_request(req_type_t'(req_ch.req_type), req_ch.priority_req,
                                   req_ch.item_id);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_result.item = rsp_ch.out_item;
                got_result.status = status_t'(rsp_ch.status);
                got_result.level = rsp_ch.served_level;
                got_result.quant = rsp_ch.quantum_size;
                got_result.all_empty = rsp_ch.all_empty;
                model.check_result(got_result);
            end
        end
    end

    // no transfer on any channel for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("multilevel_priority_fifo_unit: mismatch");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // result side pacing, including the long hold
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_rsp = 1'b0;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    task automatic send(req_type_t t, logic [PRIO_W-1:0] pr, logic [ITEM_W-1:0] id);
        int n;
        req_ch.valid <= 1'b1;
        req_ch.req_type <= t;
        req_ch.priority_req <= pr;
        req_ch.item_id <= id;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent++;
        @(negedge clk);
        n = burst ? 0 : gap_len();
        if (n > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (model.pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr <= r;
        cfg_ch.data <= d;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    task automatic program_quantum(base_t b, step_t s);
        logic [CFG_DATA_W-1:0] sd;
        sd = CFG_DATA_W'($urandom);
        sd[STEP_W-1:0] = s;
        if ($urandom_range(0, 1))
        begin
            write_reg(CFG_QUANTUM_BASE, CFG_DATA_W'(b));
            write_reg(CFG_QUANTUM_STEP, sd);
        end
        else
        begin
            write_reg(CFG_QUANTUM_STEP, sd);
            write_reg(CFG_QUANTUM_BASE, CFG_DATA_W'(b));
        end
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic mixed_run(int count);
        int r;
        logic [PRIO_W-1:0] pr;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            pr = ($urandom_range(0, 3) != 0) ? PRIO_W'($urandom_range(0, 3))
                                              : PRIO_W'($urandom_range(0, 15));
            if (r < 40)
                send(REQ_ENQ, pr, ITEM_W'($urandom));
            else if (r < 72)
                send(REQ_DEQ, PRIO_W'($urandom), ITEM_W'($urandom));
            else if (r < 86)
                send(REQ_PEEK, PRIO_W'($urandom), ITEM_W'($urandom));
            else
                send(REQ_QUANTUM, pr, ITEM_W'($urandom));
        end
    endtask

    // push one level past full
    task automatic fill_level();
        int lv;
        int k;
        lv = $urandom_range(0, LEVELS - 1);
        k = LEVEL_DEPTH - model.level_fifo[lv].size() + $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send(REQ_PEEK, PRIO_W'($urandom), ITEM_W'($urandom));
            send(REQ_ENQ, PRIO_W'(lv), ITEM_W'($urandom));
        end
    endtask

    // empty every level, then a few requests on the empty queue
    task automatic drain();
        int k;
        k = model.queued() + $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send(REQ_PEEK, PRIO_W'($urandom), ITEM_W'($urandom));
            send(REQ_DEQ, PRIO_W'($urandom), ITEM_W'($urandom));
        end
    endtask

    initial
    begin
        int target;
        int pick;
        model = new;
        rst_n = 1'b0;
        hold_rsp = 1'b0;
        burst = 1'b0;
        idle_on = 1'b1;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_ENQ;
        req_ch.priority_req = '0;
        req_ch.item_id = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = CFG_QUANTUM_BASE;
        cfg_ch.data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset quantum settings, empty queue, priority order
        send(REQ_QUANTUM, 4'd0, 16'h1234);
        send(REQ_QUANTUM, 4'd15, 16'hFFFF);
        send(REQ_DEQ, 4'd0, 16'h0000);
        send(REQ_PEEK, 4'd9, 16'hA5A5);
        send(REQ_ENQ, 4'd15, 16'hFFFF);
        send(REQ_ENQ, 4'd15, 16'h0000);
        send(REQ_ENQ, 4'd0, 16'h8001);
        send(REQ_PEEK, 4'd15, 16'h0000);
        send(REQ_DEQ, 4'd15, 16'h0000);
        send(REQ_PEEK, 4'd0, 16'h0000);
        send(REQ_DEQ, 4'd0, 16'h0000);
        send(REQ_ENQ, 4'd7, 16'h5A5A);
        send(REQ_DEQ, 4'd0, 16'hFFFF);
        send(REQ_DEQ, 4'd0, 16'h0000);
        send(REQ_DEQ, 4'd0, 16'h0000);
        send(REQ_PEEK, 4'd0, 16'h0000);
        send(REQ_QUANTUM, 4'd8, 16'h0000);
        send(REQ_ENQ, 4'd3, 16'h7E81);
        send(REQ_QUANTUM, 4'd3, 16'h0000);
        send(REQ_DEQ, 4'd3, 16'h0000);

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            case (ph)
                0: program_quantum(base_t'(1023), step_t'(255));
                1: program_quantum(base_t'(0), step_t'(0));
                default: program_quantum(base_t'($urandom), step_t'($urandom));
            endcase
            idle_on = (ph != 1);
            if (ph == 0)
            begin
                // results held back while requests keep coming
                hold_rsp = 1'b1;
                burst = 1'b1;
                mixed_run(12);
                burst = 1'b0;
                settle();
            end
            target = sent + PHASE_ITEMS;
            while (sent < target)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    mixed_run($urandom_range(10, 40));
                else if (pick < 8)
                    fill_level();
                else
                    drain();
            end
        end

        settle();
        repeat (8) @(negedge clk);
        $display("%0d requests: %0d enqueue (%0d full), %0d dequeue, %0d peek, %0d empty",
                 sent, model.n_enq, model.n_full, model.n_deq, model.n_peek, model.n_empty);
        $display("%0d quantum queries, %0d results checked over reset, zero, max and random quanta",
                 model.n_quantum, model.n_checked);
        if (model.errors == 0)
            $display("multilevel_priority_fifo_unit: match");
        else
            $display("multilevel_priority_fifo_unit: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_req_if.sv
hw/rtl/mpq_rsp_if.sv
hw/rtl/mpq_cfg_if.sv
hw/rtl/mpq_ram.sv
hw/rtl/mpq_ctrl.sv
hw/rtl/mpq_dp.sv
hw/rtl/multilevel_priority_fifo_unit.sv
test/multilevel_priority_fifo_unit_test.sv
